>>> hdl/hcrt_pkg.sv
`default_nettype none

package hcrt_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_QUERY  = 2'd3
    } hcrt_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } hcrt_status_t;

    localparam logic [15:0] MISS_HOPS = 16'd9999;
    localparam logic [31:0] MISS_GW   = 32'd0;

    // one table slot as held in the entry RAM
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] gateway;
        logic [15:0] hops;
    } hcrt_entry_t;

    localparam int ENTRY_W = $bits(hcrt_entry_t);

    // occupancy update for one slot
    typedef struct packed {
        logic set;
        logic clr;
    } hcrt_occ_cmd_t;

endpackage

`default_nettype wire

>>> hdl/hcrt_ram.sv
`default_nettype none

module hcrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/hcrt_occupancy.sv
`default_nettype none

module hcrt_occupancy
    import hcrt_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [IW-1:0] rd_idx,
    output logic               rd_valid,
    input  wire hcrt_occ_cmd_t cmd,
    input  wire logic [IW-1:0] wr_idx,
    output logic      [CW-1:0] count,
    output logic      [CW-1:0] count_next
);

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [CW-1:0]    count_reg;

    assign rd_valid = valid_reg[rd_idx];
    assign count    = count_reg;

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (cmd.set) begin
            valid_next[wr_idx] = 1'b1;
            count_next         = CW'(count_reg + 1'b1);
        end else if (cmd.clr) begin
            valid_next[wr_idx] = 1'b0;
            count_next         = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_set_clr_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.set && cmd.clr))
        else $error("occupancy set and clear in same cycle");

    a_set_free_only: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set |-> !valid_reg[wr_idx])
        else $error("set on occupied slot");

    a_clr_used_only: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr |-> valid_reg[wr_idx])
        else $error("clear on free slot");
`endif

endmodule

`default_nettype wire

>>> hdl/hop_count_route_table_core.sv
`default_nettype none

// Route table core: one request in, one result out.
// A request is accepted in S_IDLE, scanned in S_SCAN and answered in S_DECIDE, where
// the result waits for a free output register. A new request is taken only in S_IDLE,
// after the linear scan of the entry RAM read port (one slot per cycle) and decide/write.
// Reset: synchronous; slot valid bits and count are cleared directly, no sweep.
// Entry RAM contents are left as they are; only valid slots can match a key.
module hop_count_route_table_core
    import hcrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [31:0] s_dest_addr,
    input  wire logic [31:0] s_next_hop,
    input  wire logic [15:0] s_hop_count,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [15:0]      m_hops_out,
    output logic [31:0]      m_gateway_out,
    output logic [4:0]       m_entry_count
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t        state_reg, state_next;
    hcrt_kind_t    kind_reg, kind_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   gw_reg, gw_next;
    logic [15:0]   hops_reg, hops_next;

    logic [IW-1:0] issue_idx_reg, issue_idx_next;
    logic          issue_done_reg, issue_done_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;

    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]   hit_gw_reg, hit_gw_next;
    logic [15:0]   hit_hops_reg, hit_hops_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;

    logic          m_valid_reg, m_valid_next;
    hcrt_status_t  status_reg, status_next;
    logic [15:0]   hops_out_reg, hops_out_next;
    logic [31:0]   gw_out_reg, gw_out_next;
    logic [4:0]    count_out_reg, count_out_next;

    // RAM and occupancy hookup
    logic          ram_re;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    hcrt_entry_t   ram_wdata;
    hcrt_entry_t   ram_rdata;
    logic          slot_valid;
    hcrt_occ_cmd_t occ_cmd;
    logic [CW-1:0] occ_count;
    logic [CW-1:0] occ_count_next;
    logic [31:0]   count_wide;

    logic          out_load;
    hcrt_status_t  res_status;
    logic [15:0]   res_hops;
    logic [31:0]   res_gw;

    hcrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_idx_reg),
        .rdata (ram_rdata)
    );

    hcrt_occupancy #(
        .DEPTH (TABLE_DEPTH)
    ) u_occupancy (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_idx     (chk_idx_reg),
        .rd_valid   (slot_valid),
        .cmd        (occ_cmd),
        .wr_idx     (ram_waddr),
        .count      (occ_count),
        .count_next (occ_count_next)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_hops_out    = hops_out_reg;
    assign m_gateway_out = gw_out_reg;
    assign m_entry_count = count_out_reg;

    assign ram_re     = (state_reg == S_SCAN) && !issue_done_reg;
    assign out_load   = (state_reg == S_DECIDE) && (!m_valid_reg || m_ready);
    // count is reported modulo 32
    assign count_wide = 32'(occ_count_next);

    // decide: result and table write for the scanned request
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = free_idx_reg;
        ram_wdata   = '{key: key_reg, gateway: gw_reg, hops: 16'd0};
        occ_cmd     = '{set: 1'b0, clr: 1'b0};
        res_status  = ST_OK;
        res_hops    = 16'd0;
        res_gw      = 32'd0;
        unique case (kind_reg)
            KIND_INSERT: begin
                if (hit_reg) begin
                    res_status = ST_PRESENT;
                end else if (!free_reg) begin
                    res_status = ST_FULL;
                end else begin
                    ram_we      = out_load;
                    occ_cmd.set = out_load;
                end
            end
            KIND_DELETE: begin
                ram_waddr = hit_idx_reg;
                if (!hit_reg) begin
                    res_status = ST_NOT_FOUND;
                end else begin
                    occ_cmd.clr = out_load;
                end
            end
            KIND_UPDATE: begin
                ram_wdata.hops = hops_reg;
                if (hit_reg) begin
                    ram_waddr = hit_idx_reg;
                    ram_we    = out_load;
                end else if (free_reg) begin
                    ram_we      = out_load;
                    occ_cmd.set = out_load;
                end else begin
                    res_status = ST_FULL;
                end
            end
            KIND_QUERY: begin
                if (hit_reg) begin
                    res_hops = hit_hops_reg;
                    res_gw   = hit_gw_reg;
                end else begin
                    res_status = ST_NOT_FOUND;
                    res_hops   = MISS_HOPS;
                    res_gw     = MISS_GW;
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        gw_next         = gw_reg;
        hops_next       = hops_reg;
        issue_idx_next  = issue_idx_reg;
        issue_done_next = issue_done_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_gw_next     = hit_gw_reg;
        hit_hops_next   = hit_hops_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        m_valid_next    = m_valid_reg;
        status_next     = status_reg;
        hops_out_next   = hops_out_reg;
        gw_out_next     = gw_out_reg;
        count_out_next  = count_out_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next       = hcrt_kind_t'(s_kind);
                    key_next        = s_dest_addr;
                    gw_next         = s_next_hop;
                    hops_next       = s_hop_count;
                    issue_idx_next  = '0;
                    issue_done_next = 1'b0;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN: begin
                // read slot issue_idx; its data is checked next cycle
                if (!issue_done_reg) begin
                    chk_vld_next   = 1'b1;
                    chk_idx_next   = issue_idx_reg;
                    issue_idx_next = IW'(issue_idx_reg + 1'b1);
                    if (issue_idx_reg == LAST_IDX) begin
                        issue_done_next = 1'b1;
                    end
                end
                if (chk_vld_reg) begin
                    if (slot_valid && (ram_rdata.key == key_reg)) begin
                        hit_next      = 1'b1;
                        hit_idx_next  = chk_idx_reg;
                        hit_gw_next   = ram_rdata.gateway;
                        hit_hops_next = ram_rdata.hops;
                    end
                    // lowest free slot wins
                    if (!slot_valid && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                    if (chk_idx_reg == LAST_IDX) begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (out_load) begin
                    m_valid_next   = 1'b1;
                    status_next    = res_status;
                    hops_out_next  = res_hops;
                    gw_out_next    = res_gw;
                    count_out_next = count_wide[4:0];
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            issue_done_reg <= 1'b0;
            chk_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            chk_vld_reg    <= chk_vld_next;
            m_valid_reg    <= m_valid_next;
        end
        kind_reg      <= kind_next;
        key_reg       <= key_next;
        gw_reg        <= gw_next;
        hops_reg      <= hops_next;
        issue_idx_reg <= issue_idx_next;
        chk_idx_reg   <= chk_idx_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_gw_reg    <= hit_gw_next;
        hit_hops_reg  <= hit_hops_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        status_reg    <= status_next;
        hops_out_reg  <= hops_out_next;
        gw_out_reg    <= gw_out_next;
        count_out_reg <= count_out_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_accept_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_SCAN))
        else $error("accepted request did not start a scan");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid_reg && (state_reg == S_IDLE)))
        else $error("result load did not raise m_valid");

    a_write_only_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we || occ_cmd.set || occ_cmd.clr) |-> out_load)
        else $error("table written outside result load");
`endif

endmodule

`default_nettype wire
